[sv/srfg_pkg.sv]
// shared types and constants of the speed ramp frame generator
package srfg_pkg;

  localparam logic [1:0] CMD_SET   = 2'd0;
  localparam logic [1:0] CMD_SOFT  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;
  localparam logic [1:0] CMD_SPARE = 2'd3;

  localparam logic [15:0] START_MARK = 16'hABCD;

  localparam int DVD_W = 48;
  localparam int DVS_W = 32;
  localparam int MAG_W = 16;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [15:0] steer;
    logic signed [15:0] speed_value;
    logic [14:0]        ramp_ms;
    logic [31:0]        now_ms;
  } srfg_in_t;

  typedef struct packed {
    logic [15:0]        start_word;
    logic signed [15:0] steer_out;
    logic signed [15:0] speed_out;
    logic [15:0]        checksum;
  } srfg_out_t;

endpackage

[sv/srfg_ratio.sv]
// multiply then restoring divide: low 16 bits of mag * elapsed / duration
module srfg_ratio
  import srfg_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [MAG_W-1:0] mag,
  input  logic [31:0]      elapsed,
  input  logic [DVS_W-1:0] duration,
  output logic             done,
  output logic [15:0]      quo
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;

  localparam int CNT_W = $clog2(DVD_W);

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [MAG_W-1:0] mag_r, mag_nxt;
  logic [31:0]      ela_r, ela_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [DVD_W-1:0] acc_r, acc_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;

  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   sub;
  logic             ge;

  // one quotient bit per step
  assign shifted = {rem_r, acc_r[DVD_W-1]};
  assign ge      = shifted >= {1'b0, dvs_r};
  assign sub     = shifted - {1'b0, dvs_r};

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    mag_nxt   = mag_r;
    ela_nxt   = ela_r;
    dvs_nxt   = dvs_r;
    acc_nxt   = acc_r;
    rem_nxt   = rem_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          mag_nxt   = mag;
          ela_nxt   = elapsed;
          dvs_nxt   = duration;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        // full 48-bit product
        acc_nxt   = mag_r * ela_r;
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        acc_nxt = {acc_r[DVD_W-2:0], ge};
        rem_nxt = ge ? sub[DVS_W-1:0] : shifted[DVS_W-1:0];
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DVD_W - 1)) begin
          done_nxt  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= done_nxt;
    end
    mag_r <= mag_nxt;
    ela_r <= ela_nxt;
    dvs_r <= dvs_nxt;
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign quo  = acc_r[15:0];

endmodule

[sv/speed_ramp_frame_generator_unit.sv]
// top level of the speed ramp frame generator
//
// in_* channel (valid/ready, srfg_in_t) takes commands: an immediate set
// writes steer and speed, a soft set starts a linear speed ramp from the
// present speed toward speed_value over ramp_ms milliseconds stamped with
// now_ms, and a tick advances the ramp and emits one motor frame.
// out_* channel (valid/ready, srfg_out_t) carries the frames: start mark,
// steer, speed and the xor checksum of the three.
// a set item is taken and produces nothing. a tick with no ramp in
// progress, at or past the ramp end, or on a zero-length ramp goes
// through S_EMIT to the output register; a tick inside a ramp waits in
// S_CALC while srfg_ratio runs the 16x32 multiply and the restoring
// divider, one quotient bit per cycle, then goes through S_EMIT.
// one item is in work at a time; in_ready stays low until the frame
// is in the output register. a stalled receiver holds the frame there;
// a further tick finishes its arithmetic and then waits for the register
// to free up. set items that arrive before such a tick are still taken,
// since they produce no frame.
// reset (synchronous, rst_n low) clears the command, the ramp and the
// output valid.
module speed_ramp_frame_generator_unit
  import srfg_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  srfg_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output srfg_out_t out_data
);

  // sequencer codes
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CALC = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]  state_r, state_nxt;

  // command and ramp state
  logic [15:0] steer_r, steer_nxt;
  logic [15:0] speed_r, speed_nxt;
  logic [15:0] from_r, from_nxt;
  logic [15:0] to_r, to_nxt;
  logic [31:0] begin_r, begin_nxt;
  logic [31:0] finish_r, finish_nxt;
  logic        neg_r, neg_nxt;

  logic        out_valid_r, out_valid_nxt;
  srfg_out_t   out_data_r, out_data_nxt;

  // tick decode
  logic        ramp_on;
  logic        ramp_end;
  logic [31:0] elapsed;
  logic [31:0] duration;
  logic [16:0] diff;
  logic [15:0] mag;

  // multiply/divide unit
  logic        ratio_start;
  logic        ratio_done;
  logic [15:0] ratio_quo;
  logic [15:0] q16;

  assign ramp_on  = finish_r != '0;
  assign ramp_end = in_data.now_ms >= finish_r;
  assign elapsed  = in_data.now_ms - begin_r;
  assign duration = finish_r - begin_r;
  assign diff     = {to_r[15], to_r} - {from_r[15], from_r};
  // magnitude fits 16 bits: the extreme difference is 65535
  assign mag      = diff[16] ? 16'(-diff) : diff[15:0];
  // signed truncating quotient from the unsigned one
  assign q16      = neg_r ? 16'(-ratio_quo) : ratio_quo;

  srfg_ratio u_ratio (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ratio_start),
    .mag      (mag),
    .elapsed  (elapsed),
    .duration (duration),
    .done     (ratio_done),
    .quo      (ratio_quo)
  );

  always_comb begin
    state_nxt     = state_r;
    steer_nxt     = steer_r;
    speed_nxt     = speed_r;
    from_nxt      = from_r;
    to_nxt        = to_r;
    begin_nxt     = begin_r;
    finish_nxt    = finish_r;
    neg_nxt       = neg_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ratio_start   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_data.cmd)
            CMD_SET: begin
              steer_nxt = in_data.steer;
              speed_nxt = in_data.speed_value;
              from_nxt  = in_data.speed_value;
            end
            CMD_SOFT: begin
              steer_nxt  = in_data.steer;
              from_nxt   = speed_r;
              to_nxt     = in_data.speed_value;
              begin_nxt  = in_data.now_ms;
              finish_nxt = in_data.now_ms + {17'd0, in_data.ramp_ms};
            end
            CMD_TICK: begin
              state_nxt = S_EMIT;
              if (ramp_on) begin
                if (ramp_end) begin
                  // ramp over: land on the end speed and drop the ramp
                  speed_nxt  = to_r;
                  from_nxt   = '0;
                  to_nxt     = '0;
                  begin_nxt  = '0;
                  finish_nxt = '0;
                end else if (duration != '0) begin
                  neg_nxt     = diff[16];
                  ratio_start = 1'b1;
                  state_nxt   = S_CALC;
                end
              end
            end
            default: ;  // unused code: taken, no effect
          endcase
        end
      end
      S_CALC: begin
        if (ratio_done) begin
          speed_nxt = from_r + q16;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.start_word = START_MARK;
          out_data_nxt.steer_out  = steer_r;
          out_data_nxt.speed_out  = speed_r;
          out_data_nxt.checksum   = START_MARK ^ steer_r ^ speed_r;
          state_nxt               = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      steer_r     <= '0;
      speed_r     <= '0;
      from_r      <= '0;
      to_r        <= '0;
      begin_r     <= '0;
      finish_r    <= '0;
      neg_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      steer_r     <= steer_nxt;
      speed_r     <= speed_nxt;
      from_r      <= from_nxt;
      to_r        <= to_nxt;
      begin_r     <= begin_nxt;
      finish_r    <= finish_nxt;
      neg_r       <= neg_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[sv/srfg_chk.sv]
// port-level checks of the speed ramp frame generator, bound to the top level
module srfg_chk
  import srfg_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input srfg_in_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input srfg_out_t out_data
);

  // a stalled frame holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("frame changed while stalled");

  // every frame carries the start mark
  a_mark: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.start_word == START_MARK)
    else $error("bad start word");

  // checksum covers mark, steer and speed
  a_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.checksum ==
      (out_data.start_word ^ out_data.steer_out ^ out_data.speed_out))
    else $error("bad checksum");

  // a tick occupies the block for at least the next cycle
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.cmd == CMD_TICK |=> !in_ready)
    else $error("ready right after tick");

  // reset empties the output
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("frame valid after reset");

endmodule

bind speed_ramp_frame_generator_unit srfg_chk u_srfg_chk (.*);
